// ===== rtl/nearest_value_binary_search_core_defines.svh =====
// ---------------------------------------------------------------------------
// Nearest-value search core: assertion macros
// Shared property forms; each expects clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef NEAREST_VALUE_BINARY_SEARCH_CORE_DEFINES_SVH
`define NEAREST_VALUE_BINARY_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define NVBS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define NVBS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/nvbs_pkg.sv =====
// ---------------------------------------------------------------------------
// nvbs_pkg
// Defaults, port field widths, operation codes and sequencer states of the nearest-value core.
// ---------------------------------------------------------------------------
package nvbs_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	// Port field widths
	localparam int IDX_PORT_W   = 10;
	localparam int VAL_PORT_W   = 32;
	localparam int COUNT_PORT_W = 11;

	// Operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// Sequencer states, one-hot
	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SEARCH = 6'b000010,
		S_LO     = 6'b000100,
		S_HI     = 6'b001000,
		S_ZERO   = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

endpackage

// ===== rtl/nearest_value_binary_search_core.sv =====
// ---------------------------------------------------------------------------
// nearest_value_binary_search_core
// Sorted value table in one synchronous memory with a nearest-value query
// run as a binary search, one memory read per cycle.
// ---------------------------------------------------------------------------
//
// Channel  Handshake            Payload
// -------  -------------------  ----------------------------------------------
// in       in_valid / in_ready  operation, entry_index, entry_value, target,
//                               count
// out      out_valid/out_ready  nearest_value, nearest_index
//
// A write item stores one entry (none if its index is beyond the table) and
// yields no item. A query of count n (clamped to TABLE_DEPTH) runs one probe
// per cycle while the window is wider than two, then reads the final pair, or
// entry 0 alone if n is below two, and loads the output register. The single
// memory read port sets this pace. An exact hit ends the search early.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, so a new item is taken while the old one stalls.
// Reset clears control only; table contents are undefined until written.
//
`include "nearest_value_binary_search_core_defines.svh"

module nearest_value_binary_search_core #(
	parameter int TABLE_DEPTH = nvbs_pkg::DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = nvbs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              operation,
	input  logic [nvbs_pkg::IDX_PORT_W-1:0]   entry_index,
	input  logic [nvbs_pkg::VAL_PORT_W-1:0]   entry_value,
	input  logic [nvbs_pkg::VAL_PORT_W-1:0]   target,
	input  logic [nvbs_pkg::COUNT_PORT_W-1:0] count,
	// output channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nvbs_pkg::VAL_PORT_W-1:0]   nearest_value,
	output logic [nvbs_pkg::IDX_PORT_W-1:0]   nearest_index
);

	import nvbs_pkg::*;

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// ------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------
	state_t                 state_q, state_d;

	logic [VALUE_WIDTH-1:0] store_q [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] rd_data_q;
	logic [IDX_W-1:0]       rd_addr;

	logic                   in_fire;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [VALUE_WIDTH-1:0] wr_data;
	logic [63:0]            idx_ext;
	logic [63:0]            val_ext;
	logic [63:0]            tgt_ext;
	logic [31:0]            cnt_ext;
	logic [31:0]            cnt_clamp;
	logic [CNT_W-1:0]       cnt_eff;
	logic [VALUE_WIDTH-1:0] tgt_in;

	// search registers
	logic [IDX_W-1:0]       base_q;
	logic [CNT_W-1:0]       win_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [VALUE_WIDTH-1:0] tgt_q;
	logic [VALUE_WIDTH-1:0] lo_val_q;
	logic [VALUE_WIDTH-1:0] dlo_q;
	logic [VALUE_WIDTH-1:0] res_val_q;
	logic [IDX_W-1:0]       res_idx_q;

	// search step
	logic [CNT_W-1:0]       half;
	logic [CNT_W-1:0]       probe_sum;
	logic [IDX_W-1:0]       probe_idx;
	logic                   probe_lt;
	logic                   probe_gt;
	logic [IDX_W-1:0]       nbase;
	logic [CNT_W-1:0]       nwin;
	logic [CNT_W-1:0]       nprobe_sum;
	logic [IDX_W-1:0]       base_p1;
	logic [VALUE_WIDTH-1:0] diff_rd;

	// output register
	logic                   out_valid_q;
	logic [31:0]            nearest_value_q;
	logic [9:0]             nearest_index_q;
	logic                   out_load;
	logic [63:0]            res_val_ext;
	logic [63:0]            res_idx_ext;

	// ------------------------------------------------------------------
	// Input decode: clamp count, fit widths to the table
	// ------------------------------------------------------------------
	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid & in_ready;

	assign idx_ext   = 64'(entry_index);
	assign val_ext   = 64'(entry_value);
	assign tgt_ext   = 64'(target);
	assign cnt_ext   = 32'(count);
	assign cnt_clamp = (cnt_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cnt_ext;
	assign cnt_eff   = cnt_clamp[CNT_W-1:0];
	assign tgt_in    = tgt_ext[VALUE_WIDTH-1:0];

	// drop writes beyond the table
	assign wr_en   = in_fire && (operation == OP_WRITE) && (idx_ext < 64'(TABLE_DEPTH));
	assign wr_addr = idx_ext[IDX_W-1:0];
	assign wr_data = val_ext[VALUE_WIDTH-1:0];

	// ------------------------------------------------------------------
	// Table memory: one write port, one registered read port
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_data_q <= store_q[rd_addr];
	end

	// ------------------------------------------------------------------
	// Search step: rd_data_q holds the entry at base + win/2
	// ------------------------------------------------------------------
	assign half      = win_q >> 1;
	assign probe_sum = CNT_W'(base_q) + half;
	assign probe_idx = probe_sum[IDX_W-1:0];
	assign probe_lt  = rd_data_q < tgt_q;
	assign probe_gt  = rd_data_q > tgt_q;

	// below target: move the window up; above: shrink it onto the probe
	assign nbase      = probe_lt ? probe_idx : base_q;
	assign nwin       = probe_lt ? (win_q - half) : (half + CNT_W'(1));
	assign nprobe_sum = CNT_W'(nbase) + (nwin >> 1);
	assign base_p1    = base_q + IDX_W'(1);

	assign diff_rd = (tgt_q > rd_data_q) ? (tgt_q - rd_data_q) : (rd_data_q - tgt_q);

	// ------------------------------------------------------------------
	// Sequencer and read address
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				// prime the first probe, or entry 0 for short tables
				if (cnt_eff > CNT_W'(2)) begin
					rd_addr = IDX_W'(cnt_eff >> 1);
				end
				if (in_fire && (operation == OP_QUERY)) begin
					if (cnt_eff > CNT_W'(2)) begin
						state_d = S_SEARCH;
					end else if (cnt_eff == CNT_W'(2)) begin
						state_d = S_LO;
					end else begin
						state_d = S_ZERO;
					end
				end
			end
			S_SEARCH: begin
				if (!probe_lt && !probe_gt) begin
					state_d = S_DONE;
				end else if (nwin > CNT_W'(2)) begin
					rd_addr = nprobe_sum[IDX_W-1:0];
				end else begin
					rd_addr = nbase;
					state_d = S_LO;
				end
			end
			S_LO: begin
				rd_addr = base_p1;
				state_d = S_HI;
			end
			S_HI: begin
				state_d = S_DONE;
			end
			S_ZERO: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ------------------------------------------------------------------
	// Search datapath registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire && (operation == OP_QUERY)) begin
					base_q <= '0;
					win_q  <= cnt_eff;
					cnt_q  <= cnt_eff;
					tgt_q  <= tgt_in;
				end
			end
			S_SEARCH: begin
				if (!probe_lt && !probe_gt) begin
					// exact hit ends the search
					res_val_q <= rd_data_q;
					res_idx_q <= probe_idx;
				end else begin
					base_q <= nbase;
					win_q  <= nwin;
				end
			end
			S_LO: begin
				lo_val_q <= rd_data_q;
				dlo_q    <= diff_rd;
			end
			S_HI: begin
				// tie goes to the lower entry
				if (dlo_q <= diff_rd) begin
					res_val_q <= lo_val_q;
					res_idx_q <= base_q;
				end else begin
					res_val_q <= rd_data_q;
					res_idx_q <= base_p1;
				end
			end
			S_ZERO: begin
				res_val_q <= rd_data_q;
				res_idx_q <= '0;
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: hold the result until taken
	// ------------------------------------------------------------------
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign res_val_ext = 64'(res_val_q);
	assign res_idx_ext = 64'(res_idx_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			nearest_value_q <= res_val_ext[31:0];
			nearest_index_q <= res_idx_ext[9:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign nearest_value = nearest_value_q;
	assign nearest_index = nearest_index_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`NVBS_ASSERT_IMP(a_search_wide, (state_q == S_SEARCH), (win_q > CNT_W'(2)), "probe with narrow window")
	`NVBS_ASSERT_IMP(a_pair_in_range, (state_q == S_LO || state_q == S_HI), (win_q == CNT_W'(2) && ((CNT_W+1)'(base_q) + (CNT_W+1)'(2)) <= (CNT_W+1)'(cnt_q)), "final pair outside count")
	`NVBS_ASSERT_NXT(a_done_loads, out_load, (out_valid && state_q == S_IDLE), "result not delivered")

endmodule
